// File: hw/rtl/ptc_pkg.sv
// Shared types, constants and helpers for the pressure/temperature compensation core.
// No dependencies; imported by the core and by its port checker.
package ptc_pkg;

	localparam int RAW_W      = 24;
	localparam int WORD_W     = 32;
	localparam int TEMP_W     = 17;
	localparam int IN_TDATA_W = 48;
	localparam int OUT_TDATA_W = 56;
	localparam int CAL_REGS   = 5;
	localparam int CAL_WORDS  = 10;
	localparam int PADDR_W    = 5;
	localparam int NUM_STG    = 17;
	localparam int FRAC_W     = 11;

	// Register map, index = paddr / 4
	typedef enum logic [2:0] {
		REG_W01 = 3'd0,
		REG_W23 = 3'd1,
		REG_W45 = 3'd2,
		REG_W67 = 3'd3,
		REG_W89 = 3'd4
	} reg_idx_t;

	localparam logic [31:0] RAW_OFS = 32'd8388608;
	localparam logic [31:0] C1_OFS  = 32'd4459;
	localparam logic [31:0] C2_OFS  = 32'd256;
	localparam logic [31:0] RT_BASE = 32'd81920000;
	localparam logic [31:0] C5_OFS  = 32'd4443;
	localparam logic [31:0] C4_OFS  = 32'd120586;
	localparam logic [31:0] C8_OFS  = 32'd7180;
	localparam logic [31:0] C7_OFS  = 32'd166426;
	localparam logic [31:0] CF_BASE = 32'd2097152;
	localparam logic [31:0] RP_OFS  = 32'd99880;

	localparam logic signed [31:0] T_LO = -32'sd4000;
	localparam logic signed [31:0] T_HI = 32'sd8500;
	localparam logic signed [31:0] P_LO = 32'sd1000;
	localparam logic signed [31:0] P_HI = 32'sd120000;

	// 32-bit arithmetic right shift, sign propagating
	function automatic logic [31:0] asr32(input logic [31:0] v, input int unsigned n);
		logic signed [31:0] sv;
		sv = $signed(v);
		return $unsigned(sv >>> n);
	endfunction

	function automatic logic slt32(input logic [31:0] a, input logic [31:0] b);
		return $signed(a) < $signed(b);
	endfunction

endpackage

// File: hw/rtl/pressure_temperature_compensation_core.sv
// Compensation core: raw 24-bit pressure/temperature pair in, pascals and 0.01 C out.
// Depends on ptc_pkg; calibration words sit in five APB-written registers.
//
//  channel   dir  handshake               payload
//  s_axis    in   tvalid/tready           tdata: raw_pressure, raw_temperature
//  m_axis    out  tvalid/tready           tdata: pressure_pa, temperature_centi; tuser: in_range
//  apb       in   psel/penable/pready     five 32-bit calibration registers
//
// Seventeen register stages, s1 to s17, one beat in per cycle unless the output beat is held.
// Depth is set by the chain of dependent 32x32 multiplies.
// All stages advance together; when the output beat is held, every stage holds.
// Reset clears the valid bits and the calibration registers.
module pressure_temperature_compensation_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	// [23:0] raw_pressure, [47:24] raw_temperature
	input  logic [ptc_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	// [31:0] pressure_pa, [48:32] temperature_centi, [55:49] zero
	output logic [ptc_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	// [0] in_range
	output logic                         m_axis_tuser,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [ptc_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);
	import ptc_pkg::*;

	logic [31:0]  cal_q [CAL_REGS];
	logic [15:0]  w [CAL_WORDS];
	logic         reg_hit;

	logic [11:0] c0;
	logic [10:0] c1;
	logic [8:0]  c2;
	logic [12:0] c3;
	logic [17:0] c4;
	logic [14:0] c5;
	logic [12:0] c6;
	logic [18:0] c7;
	logic [12:0] c8;
	logic [13:0] c9;
	logic [9:0]  c10;
	logic [7:0]  c11;
	logic [4:0]  c12;
	logic [31:0] k;

	logic [NUM_STG-1:0] vld_q;
	logic adv;

	// ---------------- configuration port ----------------
	assign reg_hit = (32'(paddr[PADDR_W-1:2]) < CAL_REGS);
	assign pready  = 1'b1;
	assign prdata  = reg_hit ? cal_q[paddr[PADDR_W-1:2]] : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CAL_REGS; i++) cal_q[i] <= '0;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			cal_q[paddr[PADDR_W-1:2]] <= pwdata;
		end
	end

	// ---------------- coefficient unpack ----------------
	always_comb begin
		for (int i = 0; i < CAL_REGS; i++) begin
			w[2*i]   = cal_q[i][31:16];
			w[2*i+1] = cal_q[i][15:0];
		end
	end

	assign c0  = w[0][15:4];
	assign c1  = {w[1][15:8], w[2][2:0]};
	assign c2  = {w[1][7:0], w[4][0]};
	assign c3  = w[2][15:3];
	assign c4  = {w[3], w[0][1:0]};
	assign c5  = w[4][15:1];
	assign c6  = w[5][15:3];
	assign c7  = {w[6], w[5][2:0]};
	assign c8  = w[7][15:3];
	assign c9  = w[8][15:2];
	assign c10 = {w[9][15:8], w[8][1:0]};
	assign c11 = w[9][7:0];
	assign c12 = {w[0][3:2], w[7][2:0]};
	assign k   = 32'(c7) + C7_OFS;

	// ---------------- pipeline control ----------------
	assign adv           = !vld_q[NUM_STG-1] || m_axis_tready;
	assign s_axis_tready = adv;
	assign m_axis_tvalid = vld_q[NUM_STG-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[NUM_STG-2:0], s_axis_tvalid};
		end
	end

	// ---------------- datapath registers ----------------
	logic [31:0] dt_s1, upo_s1;
	logic [31:0] t1_s2, t2_s2, t3_s2, dt_s2, upo_s2;
	logic [31:0] x01_s3, t2_s3, t3_s3, dt_s3, upo_s3;
	logic [31:0] x01_s4, x02_s4, x03_s4, upo_s4;
	logic [31:0] rt_s5, dt2_s5, upo_s5;
	logic [31:0] x11_s6, a12_s6, m21_s6, a22_s6, cfp_s6, dt2_s6, rt_s6, upo_s6;
	logic [31:0] x11_s7, x12p_s7, x21_s7, x22p_s7, cf_s7, rt_s7, upo_s7;
	logic [31:0] x13_s8, x21_s8, x22_s8, e10_s8, e11_s8, rt_s8, upo_s8;
	logic [31:0] x23_s9, pp1_s9, e10_s9, e11_s9, rt_s9;
	logic        neg_s9;
	logic [31:0] x24_s10, x25p_s10, pp1_s10, e10_s10, e11_s10, rt_s10;
	logic        neg_s10;
	logic [31:0] x26_s11, pp1_s11, e10_s11, e11_s11, rt_s11;
	logic [31:0] pp2_s12, pp3p_s12, e10_s12, e11_s12, rt_s12;
	logic [31:0] pp4_s13, f10_s13, f11_s13, rt_s13;
	logic [31:0] y31_s14, y32_s14, pp4_s14, rt_s14;
	logic [31:0] x31_s15, x32_s15, pp4_s15, rt_s15;
	logic [31:0] rp_s16, rt_s16;
	logic [31:0]       pres_s17;
	logic [TEMP_W-1:0] temp_s17;
	logic              ok_s17;

	logic [31:0] x25_c, xsum_c;

	always_comb begin
		x25_c  = asr32(x25p_s10, FRAC_W);
		xsum_c = neg_s10 ? (32'd0 - x24_s10 - x25_c) : (x24_s10 + x25_c);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// s1: temperature delta, pressure offset
			dt_s1  <= asr32(32'(s_axis_tdata[2*RAW_W-1:RAW_W]) - RAW_OFS, 4) + (32'(c0) << 4);
			upo_s1 <= 32'(s_axis_tdata[RAW_W-1:0]) - RAW_OFS;
			// s2: first products of dt
			t1_s2  <= (32'(c1) + C1_OFS) * dt_s1;
			t2_s2  <= (32'(c2) - C2_OFS) * dt_s1;
			t3_s2  <= 32'(c3) * dt_s1;
			dt_s2  <= dt_s1;
			upo_s2 <= upo_s1;
			// s3
			x01_s3 <= asr32(t1_s2, 1);
			t2_s3  <= asr32(t2_s2, 14) * dt_s2;
			t3_s3  <= asr32(t3_s2, 18) * dt_s2;
			dt_s3  <= dt_s2;
			upo_s3 <= upo_s2;
			// s4
			x01_s4 <= x01_s3;
			x02_s4 <= asr32(t2_s3, 4);
			x03_s4 <= asr32(t3_s3, 18) * dt_s3;
			upo_s4 <= upo_s3;
			// s5: temperature result and scaled delta
			rt_s5  <= asr32(RT_BASE - x01_s4 - x02_s4 - x03_s4, 15);
			dt2_s5 <= asr32(x01_s4 + x02_s4 + x03_s4, 12);
			upo_s5 <= upo_s4;
			// s6: products of dt2
			x11_s6 <= (32'(c5) - C5_OFS) * dt2_s5;
			a12_s6 <= 32'(c6) * dt2_s5;
			m21_s6 <= (32'(c8) + C8_OFS) * dt2_s5;
			a22_s6 <= 32'(c9) * dt2_s5;
			cfp_s6 <= 32'(c12) * dt2_s5;
			dt2_s6 <= dt2_s5;
			rt_s6  <= rt_s5;
			upo_s6 <= upo_s5;
			// s7
			x11_s7  <= x11_s6;
			x12p_s7 <= asr32(a12_s6, 16) * dt2_s6;
			x21_s7  <= asr32(m21_s6, 10);
			x22p_s7 <= asr32(a22_s6, 17) * dt2_s6;
			cf_s7   <= asr32(CF_BASE + cfp_s6, 3);
			rt_s7   <= rt_s6;
			upo_s7  <= upo_s6;
			// s8: offset term, second-order factors
			x13_s8 <= asr32(x11_s7 + asr32(x12p_s7, 2), 10) + ((32'(c4) + C4_OFS) << 4);
			x21_s8 <= x21_s7;
			x22_s8 <= asr32(x22p_s7, 12);
			e10_s8 <= cf_s7 * 32'(c10);
			e11_s8 <= cf_s7 * 32'(c11);
			rt_s8  <= rt_s7;
			upo_s8 <= upo_s7;
			// s9: magnitude of sensitivity difference
			x23_s9 <= slt32(x22_s8, x21_s8) ? (x21_s8 - x22_s8) : (x22_s8 - x21_s8);
			neg_s9 <= (x22_s8 - x21_s8) >> 31 != 32'd0;
			pp1_s9 <= asr32(upo_s8 - x13_s8, 3);
			e10_s9 <= e10_s8;
			e11_s9 <= e11_s8;
			rt_s9  <= rt_s8;
			// s10
			x24_s10  <= asr32(x23_s9, FRAC_W) * k;
			x25p_s10 <= 32'(x23_s9[FRAC_W-1:0]) * k;
			neg_s10  <= neg_s9;
			pp1_s10  <= pp1_s9;
			e10_s10  <= e10_s9;
			e11_s10  <= e11_s9;
			rt_s10   <= rt_s9;
			// s11: sensitivity
			x26_s11 <= asr32(xsum_c, FRAC_W) + k;
			pp1_s11 <= pp1_s10;
			e10_s11 <= e10_s10;
			e11_s11 <= e11_s10;
			rt_s11  <= rt_s10;
			// s12
			pp2_s12  <= asr32(x26_s11, FRAC_W) * pp1_s11;
			pp3p_s12 <= 32'(x26_s11[FRAC_W-1:0]) * pp1_s11;
			e10_s12  <= e10_s11;
			e11_s12  <= e11_s11;
			rt_s12   <= rt_s11;
			// s13: first-order pressure
			pp4_s13 <= asr32(pp2_s12 + asr32(pp3p_s12, FRAC_W), 10);
			f10_s13 <= asr32(e10_s12, 17);
			f11_s13 <= asr32(e11_s12, 15);
			rt_s13  <= rt_s12;
			// s14
			y31_s14 <= f10_s13 * pp4_s13;
			y32_s14 <= f11_s13 * pp4_s13;
			pp4_s14 <= pp4_s13;
			rt_s14  <= rt_s13;
			// s15
			x31_s15 <= asr32(y31_s14, 2);
			x32_s15 <= asr32(y32_s14, 18) * pp4_s14;
			pp4_s15 <= pp4_s14;
			rt_s15  <= rt_s14;
			// s16: final pressure
			rp_s16 <= asr32(x31_s15 + x32_s15, 15) + pp4_s15 + RP_OFS;
			rt_s16 <= rt_s15;
			// s17: output beat and plausibility window
			pres_s17 <= rp_s16;
			temp_s17 <= rt_s16[TEMP_W-1:0];
			ok_s17   <= ($signed(rt_s16) > T_LO) && ($signed(rt_s16) < T_HI) &&
			            ($signed(rp_s16) > P_LO) && ($signed(rp_s16) < P_HI);
		end
	end

	assign m_axis_tdata = {{(OUT_TDATA_W - WORD_W - TEMP_W){1'b0}}, temp_s17, pres_s17};
	assign m_axis_tuser = ok_s17;

endmodule

// File: hw/rtl/ptc_checker.sv
// Port-level checker for the compensation core, attached by bind.
// Depends on ptc_pkg for port widths and window bounds.
module ptc_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_axis_tready,
	input logic                            m_axis_tvalid,
	input logic                            m_axis_tready,
	input logic [ptc_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	input logic                            m_axis_tuser,
	input logic                            psel,
	input logic                            penable,
	input logic                            pwrite,
	input logic [ptc_pkg::PADDR_W-1:0]     paddr,
	input logic [31:0]                     pwdata,
	input logic [31:0]                     prdata,
	input logic                            pready
);
	import ptc_pkg::*;

	logic signed [31:0]       pres;
	logic signed [TEMP_W-1:0] temp;

	assign pres      = $signed(m_axis_tdata[WORD_W-1:0]);
	assign temp      = $signed(m_axis_tdata[WORD_W+TEMP_W-1:WORD_W]);

	// held output beat stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
		&& $stable(m_axis_tuser))
		else $error("output beat changed while stalled");

	// a blocked output stalls the whole pipe, so no beat enters
	a_stall_in: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
		else $error("input taken while output blocked");

	// the flag implies both fields lie in the window
	a_window: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |->
		pres > P_LO && pres < P_HI && 32'(temp) > T_LO && 32'(temp) < T_HI)
		else $error("in_range set on out-of-window result");

	// a write to the first register reads back
	a_readback: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && pready && paddr[PADDR_W-1:2] == REG_W01 |=>
		paddr[PADDR_W-1:2] != REG_W01 || prdata == $past(pwdata))
		else $error("calibration register readback mismatch");

endmodule

bind pressure_temperature_compensation_core ptc_checker u_ptc_checker (.*);
